// ----- hw/rtl/tme_pkg.sv -----
// ----------------------------------------------------------------------------
// tme_pkg
// Shared types and constants of the tape machine operation executor.
// ----------------------------------------------------------------------------
package tme_pkg;

  localparam int TAPE_LENGTH_DEF = 32768;
  localparam int CELL_BITS_DEF   = 8;

  // Operation codes as they arrive in the op field.
  typedef enum logic [2:0] {
    OP_ADD      = 3'd0,
    OP_ADP      = 3'd1,
    OP_MUL      = 3'd2,
    OP_CONST    = 3'd3,
    OP_OUT      = 3'd4,
    OP_IN       = 3'd5,
    OP_LOOP     = 3'd6,
    OP_END_LOOP = 3'd7
  } op_t;

  // One input item.
  typedef struct packed {
    op_t                op;
    logic signed [15:0] arg_a;
    logic signed [15:0] arg_b;
    logic        [7:0]  in_value;
  } op_item_t;

  // One result item.
  typedef struct packed {
    logic       out_valid;
    logic [7:0] out_char;
    logic       cell_is_zero;
  } result_t;

  // Execute stage sequencing.
  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_RUN,
    ST_SECOND
  } exec_state_t;

endpackage

// ----- hw/rtl/tme_ram.sv -----
// ----------------------------------------------------------------------------
// tme_ram
// Generic single-port synchronous RAM with a registered read port.
// ----------------------------------------------------------------------------
module tme_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     en,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Read data holds its value until the next read access.
  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end else begin
        rdata <= mem[addr];
      end
    end
  end

endmodule

// ----- hw/rtl/tme_disp.sv -----
// ----------------------------------------------------------------------------
// tme_disp
// Four-stage pipeline that reduces the signed 16-bit step or offset of an
// item into a displacement in the range [0, TAPE_LENGTH).
// ----------------------------------------------------------------------------
module tme_disp #(
  parameter int TAPE_LENGTH = tme_pkg::TAPE_LENGTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  tme_pkg::op_item_t              in_item,
  output logic                           out_valid,
  input  logic                           out_ready,
  output tme_pkg::op_item_t              out_item,
  output logic [$clog2(TAPE_LENGTH)-1:0] out_disp
);

  import tme_pkg::*;

  localparam int PW = $clog2(TAPE_LENGTH);
  localparam int LW = PW + 1;
  localparam int QW = 16 + LW;
  // Magnitudes never exceed 32768, so longer tapes need no reduction at all.
  localparam bit USE_RECIP = (TAPE_LENGTH <= 32768);
  localparam logic [63:0] RECIP64 =
    ((64'd1 << 32) + 64'(TAPE_LENGTH) - 64'd1) / 64'(TAPE_LENGTH);
  localparam logic [31:0] RECIP = USE_RECIP ? RECIP64[31:0] : 32'd0;

  logic en1, en2, en3, en4;

  logic          v1_r, v2_r, v3_r, v4_r;
  op_item_t      it1_r, it2_r, it3_r, it4_r;
  logic          neg1_r, neg2_r, neg3_r;
  logic [15:0]   abs1_r, abs2_r;
  logic [15:0]   q2_r;
  logic [PW-1:0] r3_r;
  logic [PW-1:0] disp4_r;

  logic [15:0]   abs_in;
  logic [47:0]   recip_prod;
  logic [QW-1:0] q_times_len;
  logic [QW-1:0] rem_full;
  logic [LW-1:0] len_minus_r;
  logic [PW-1:0] disp_nxt;

  assign en4 = !v4_r || out_ready;
  assign en3 = !v3_r || en4;
  assign en2 = !v2_r || en3;
  assign en1 = !v1_r || en2;
  assign in_ready = en1;

  assign abs_in = in_item.arg_a[15] ? (~in_item.arg_a + 16'd1) : in_item.arg_a;

  // Quotient by multiplication with the rounded-up reciprocal; exact for
  // every magnitude that a 16-bit argument can have.
  assign recip_prod  = 48'(abs1_r) * 48'(RECIP);
  assign q_times_len = QW'(q2_r) * QW'(TAPE_LENGTH);
  assign rem_full    = QW'(abs2_r) - q_times_len;
  assign len_minus_r = LW'(TAPE_LENGTH) - {1'b0, r3_r};
  assign disp_nxt    = (neg3_r && (r3_r != '0)) ? len_minus_r[PW-1:0] : r3_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      if (en1) v1_r <= in_valid;
      if (en2) v2_r <= v1_r;
      if (en3) v3_r <= v2_r;
      if (en4) v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      it1_r  <= in_item;
      neg1_r <= in_item.arg_a[15];
      abs1_r <= abs_in;
    end
    if (en2) begin
      it2_r  <= it1_r;
      neg2_r <= neg1_r;
      abs2_r <= abs1_r;
      q2_r   <= recip_prod[47:32];
    end
    if (en3) begin
      it3_r  <= it2_r;
      neg3_r <= neg2_r;
      r3_r   <= rem_full[PW-1:0];
    end
    if (en4) begin
      it4_r   <= it3_r;
      disp4_r <= disp_nxt;
    end
  end

  assign out_valid = v4_r;
  assign out_item  = it4_r;
  assign out_disp  = disp4_r;

endmodule

// ----- hw/rtl/tape_machine_op_executor.sv -----
// ----------------------------------------------------------------------------
// tape_machine_op_executor
// Data side of an optimized tape-language machine: a tape of cells in one
// single-port RAM, a cell pointer and one result item per operation.
// ----------------------------------------------------------------------------
// Usage. Operation items enter on the in_ channel (valid/ready) and every
// item returns exactly one result item on the out_ channel, in order. The
// result tells whether a character was emitted and whether the current cell
// is zero after the operation, which the caller uses to branch on loops.
//
// Each item first goes through a four-stage reduction pipeline for its
// step or offset and then through the execute stage, which registers its
// result in the output register. The execute stage completes most
// operations in ST_RUN alone; pointer moves and multiply-adds go on to
// ST_SECOND, because the single RAM port must read the target cell before
// the following cycle can load or write it. Throughput is one item per
// cycle while the receiver takes results and no pointer move or
// multiply-add holds the execute stage in ST_SECOND.
//
// After reset the tape is cleared by a sweep that writes one cell per
// cycle over all TAPE_LENGTH cells; in_ready stays low until it finishes.
// When the receiver stalls, the result waits in the output register, the
// execute stage holds and the reduction pipeline fills before in_ready falls.
// ----------------------------------------------------------------------------
module tape_machine_op_executor #(
  parameter int TAPE_LENGTH = tme_pkg::TAPE_LENGTH_DEF,
  parameter int CELL_BITS   = tme_pkg::CELL_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  tme_pkg::op_item_t in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output tme_pkg::result_t  out_data
);

  import tme_pkg::*;

  localparam int PW = $clog2(TAPE_LENGTH);
  localparam int LW = PW + 1;

  // Reduction pipeline handshake toward the execute stage.
  logic          disp_in_ready;
  logic          dq_valid;
  logic          dq_ready;
  op_item_t      dq_item;
  logic [PW-1:0] dq_disp;

  // Tape RAM port.
  logic                 ram_en;
  logic                 ram_we;
  logic [PW-1:0]        ram_addr;
  logic [CELL_BITS-1:0] ram_wdata;
  logic [CELL_BITS-1:0] ram_rdata;

  // Execute stage state. The current cell is mirrored in cur_r, so only
  // pointer moves and multiply-adds read the tape RAM.
  exec_state_t          st_r, st_nxt;
  logic [PW-1:0]        clr_addr_r, clr_addr_nxt;
  logic [PW-1:0]        ptr_r, ptr_nxt;
  logic [CELL_BITS-1:0] cur_r, cur_nxt;
  op_t                  x_op_r, x_op_nxt;
  logic [PW-1:0]        x_tgt_r, x_tgt_nxt;
  logic [CELL_BITS-1:0] x_prod_r, x_prod_nxt;
  logic                 ov_r, ov_nxt;
  result_t              od_r, od_nxt;

  logic                 out_free;
  logic [LW-1:0]        tgt_sum;
  logic [PW-1:0]        tgt;
  logic [31:0]          a_ext;
  logic [31:0]          b_ext;
  logic [31:0]          ch_ext;
  logic [CELL_BITS-1:0] a_cell;
  logic [CELL_BITS-1:0] b_cell;
  logic [CELL_BITS-1:0] ch_cell;
  logic [CELL_BITS-1:0] mul_sum;
  logic [CELL_BITS-1:0] new_cell;
  logic                 wr_cur;

  tme_disp #(
    .TAPE_LENGTH(TAPE_LENGTH)
  ) u_disp (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid && (st_r != ST_CLEAR)),
    .in_ready (disp_in_ready),
    .in_item  (in_data),
    .out_valid(dq_valid),
    .out_ready(dq_ready),
    .out_item (dq_item),
    .out_disp (dq_disp)
  );

  tme_ram #(
    .WIDTH(CELL_BITS),
    .DEPTH(TAPE_LENGTH)
  ) u_tape (
    .clk  (clk),
    .en   (ram_en),
    .we   (ram_we),
    .addr (ram_addr),
    .wdata(ram_wdata),
    .rdata(ram_rdata)
  );

  assign in_ready = disp_in_ready && (st_r != ST_CLEAR);
  assign out_free = !ov_r || out_ready;

  // Target cell of a move or multiply-add, wrapped around the tape.
  assign tgt_sum = {1'b0, ptr_r} + {1'b0, dq_disp};
  assign tgt     = (tgt_sum >= LW'(TAPE_LENGTH)) ?
                   PW'(tgt_sum - LW'(TAPE_LENGTH)) : tgt_sum[PW-1:0];

  // Arguments brought to cell width: sign-extended (the input value zero-extended) and truncated.
  assign a_ext   = {{16{dq_item.arg_a[15]}}, dq_item.arg_a};
  assign a_cell  = a_ext[CELL_BITS-1:0];
  assign b_ext   = {{16{dq_item.arg_b[15]}}, dq_item.arg_b};
  assign b_cell  = b_ext[CELL_BITS-1:0];
  assign ch_ext  = {24'd0, dq_item.in_value};
  assign ch_cell = ch_ext[CELL_BITS-1:0];

  // The product was registered in ST_RUN; only the add is left.
  assign mul_sum = ram_rdata + x_prod_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r       <= ST_CLEAR;
      clr_addr_r <= '0;
      ptr_r      <= '0;
      cur_r      <= '0;
      ov_r       <= 1'b0;
    end else begin
      st_r       <= st_nxt;
      clr_addr_r <= clr_addr_nxt;
      ptr_r      <= ptr_nxt;
      cur_r      <= cur_nxt;
      ov_r       <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    x_op_r   <= x_op_nxt;
    x_tgt_r  <= x_tgt_nxt;
    x_prod_r <= x_prod_nxt;
    od_r     <= od_nxt;
  end

  always_comb begin
    st_nxt       = st_r;
    clr_addr_nxt = clr_addr_r;
    ptr_nxt      = ptr_r;
    cur_nxt      = cur_r;
    x_op_nxt     = x_op_r;
    x_tgt_nxt    = x_tgt_r;
    x_prod_nxt   = x_prod_r;
    ov_nxt       = ov_r && !out_ready;
    od_nxt       = od_r;
    ram_en       = 1'b0;
    ram_we       = 1'b0;
    ram_addr     = ptr_r;
    ram_wdata    = cur_r;
    dq_ready     = 1'b0;
    new_cell     = cur_r;
    wr_cur       = 1'b0;

    case (st_r)
      ST_CLEAR: begin
        // Zero the tape one cell per cycle after reset.
        ram_en    = 1'b1;
        ram_we    = 1'b1;
        ram_addr  = clr_addr_r;
        ram_wdata = '0;
        if (clr_addr_r == PW'(TAPE_LENGTH - 1)) begin
          st_nxt = ST_RUN;
        end else begin
          clr_addr_nxt = clr_addr_r + 1'b1;
        end
      end

      ST_RUN: begin
        if (dq_valid) begin
          if (dq_item.op inside {OP_ADP, OP_MUL}) begin
            // In ST_RUN: read the target cell and form the product. The
            // result is registered in ST_SECOND, once the output register is free.
            dq_ready   = 1'b1;
            ram_en     = 1'b1;
            ram_addr   = tgt;
            x_op_nxt   = dq_item.op;
            x_tgt_nxt  = tgt;
            x_prod_nxt = cur_r * b_cell;
            st_nxt     = ST_SECOND;
          end else if (out_free) begin
            dq_ready = 1'b1;
            ov_nxt   = 1'b1;
            od_nxt.out_valid = 1'b0;
            od_nxt.out_char  = '0;
            case (dq_item.op)
              OP_ADD: begin
                new_cell = cur_r + a_cell;
                wr_cur   = 1'b1;
              end
              OP_CONST: begin
                new_cell = a_cell;
                wr_cur   = 1'b1;
              end
              OP_IN: begin
                new_cell = ch_cell;
                wr_cur   = 1'b1;
              end
              OP_OUT: begin
                od_nxt.out_valid = 1'b1;
                od_nxt.out_char  = cur_r[7:0];
              end
              default: begin
                // Loop start and loop end only report the current cell.
              end
            endcase
            cur_nxt = new_cell;
            od_nxt.cell_is_zero = (new_cell == '0);
            if (wr_cur) begin
              ram_en    = 1'b1;
              ram_we    = 1'b1;
              ram_addr  = ptr_r;
              ram_wdata = new_cell;
            end
          end
        end
      end

      ST_SECOND: begin
        // The read data holds while the output side stalls.
        if (out_free) begin
          ov_nxt = 1'b1;
          od_nxt.out_valid = 1'b0;
          od_nxt.out_char  = '0;
          st_nxt = ST_RUN;
          if (x_op_r == OP_ADP) begin
            ptr_nxt = x_tgt_r;
            cur_nxt = ram_rdata;
            od_nxt.cell_is_zero = (ram_rdata == '0);
          end else begin
            ram_en    = 1'b1;
            ram_we    = 1'b1;
            ram_addr  = x_tgt_r;
            ram_wdata = mul_sum;
            // A multiply-add onto the current cell also updates the mirror.
            if (x_tgt_r == ptr_r) begin
              cur_nxt = mul_sum;
              od_nxt.cell_is_zero = (mul_sum == '0);
            end else begin
              od_nxt.cell_is_zero = (cur_r == '0);
            end
          end
        end
      end

      default: begin
        st_nxt = ST_CLEAR;
      end
    endcase
  end

  assign out_valid = ov_r;
  assign out_data  = od_r;

  // No new item reaches the execute stage while a pointer move or
  // multiply-add is still in ST_SECOND.
  a_no_take_in_second: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ST_SECOND) |-> !dq_ready)
    else $error("item taken during second cycle of an operation");

  // No item is accepted while the tape is being cleared.
  a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ST_CLEAR) |-> !in_ready)
    else $error("item accepted during tape clear");

  // The cell pointer always stays on the tape.
  a_ptr_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    ({1'b0, ptr_r} < LW'(TAPE_LENGTH)))
    else $error("cell pointer beyond tape length");

  // A pointer move leaves the mirror equal to the cell that was read.
  a_move_loads_cell: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ST_SECOND && x_op_r == OP_ADP && out_free) |=> (cur_r == $past(ram_rdata)))
    else $error("current cell not loaded after pointer move");

endmodule

// ----- bench/tape_machine_op_executor_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tape_machine_op_executor_tb
// Self-checking bench for the tape machine executor. A shadow tape and pointer
// predict the result of every accepted operation item. Results are compared
// in order, field by field, under random idling, back-pressure and a long
// output hold.
// ----------------------------------------------------------------------------
module tape_machine_op_executor_tb;
  import tme_pkg::*;

  localparam int TAPE_CELLS  = TAPE_LENGTH_DEF;
  // The limit covers the clearing sweep after reset and leaves room for
  // every item waiting out the longest gaps and stalls.
  localparam int CYCLE_LIMIT = 600000;
  // Time for the result of the slowest operation, a pointer move or multiply-add.
  localparam int SETTLE_CYCLES = 20;

  // Shadow copy of the tape and pointer. Every accepted operation item is
  // applied here at once, and its expected result waits in a queue until
  // the block returns the matching result item.
  class tape_shadow;
    bit [7:0]    cells [TAPE_CELLS];
    int unsigned ptr;
    result_t     pending_results [$];
    int          mismatches;

    // Brings a signed step into [0, TAPE_CELLS) before it is added.
    function int unsigned wrap_step(logic signed [15:0] step);
      int r;
      r = int'(step) % TAPE_CELLS;
      if (r < 0) begin
        r += TAPE_CELLS;
      end
      return r;
    endfunction

    function void note_op(op_item_t it);
      int unsigned p;
      int unsigned dst;
      bit [7:0]    prod;
      result_t     r;
      p = ptr;
      r = '0;
      case (it.op)
        OP_ADD:   cells[p] = cells[p] + it.arg_a[7:0];
        OP_ADP:   p = (p + wrap_step(it.arg_a)) % TAPE_CELLS;
        OP_MUL: begin
          // The product uses the old current cell, even when the target is
          // the current cell itself.
          dst = (p + wrap_step(it.arg_a)) % TAPE_CELLS;
          prod = cells[p] * it.arg_b[7:0];
          cells[dst] = cells[dst] + prod;
        end
        OP_CONST: cells[p] = it.arg_a[7:0];
        OP_OUT: begin
          r.out_valid = 1'b1;
          r.out_char  = cells[p];
        end
        OP_IN:    cells[p] = it.in_value;
        default: ;
      endcase
      ptr = p;
      r.cell_is_zero = (cells[p] == 8'd0);
      pending_results.push_back(r);
    endfunction

    function void check_result(result_t got);
      result_t want;
      if (pending_results.size() == 0) begin
        $error("result item with none expected: out_valid=%0d out_char=%0h zero=%0d",
               got.out_valid, got.out_char, got.cell_is_zero);
        mismatches++;
        return;
      end
      want = pending_results.pop_front();
      if (got.out_valid !== want.out_valid) begin
        $error("out_valid: expected %0d, got %0d", want.out_valid, got.out_valid);
        mismatches++;
      end
      if (got.out_char !== want.out_char) begin
        $error("out_char: expected %0h, got %0h", want.out_char, got.out_char);
        mismatches++;
      end
      if (got.cell_is_zero !== want.cell_is_zero) begin
        $error("cell_is_zero: expected %0d, got %0d", want.cell_is_zero, got.cell_is_zero);
        mismatches++;
      end
    endfunction
  endclass

  logic     clk;
  logic     rst_n;
  logic     in_valid;
  logic     in_ready;
  op_item_t in_data;
  logic     out_valid;
  logic     out_ready;
  result_t  out_data;

  tape_shadow shadow;
  int send_idle_pct;
  int stall_pct;
  int hold_left;
  int cycle_count;

  tape_machine_op_executor dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watchdog. A hung handshake ends the run here.
  initial cycle_count = 0;
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Result side. The ready line changes at the falling edge only. A long
  // hold requested by the stimulus is counted down here, in cycles, while
  // the sender keeps offering items; otherwise the stall rate of the current
  // phase applies.
  initial begin
    out_ready = 1'b0;
    hold_left = 0;
    stall_pct = 0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        out_ready <= 1'b0;
        hold_left--;
      end else begin
        out_ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  // Results are sampled at the rising edge, where both sides see the values
  // that were settled during the preceding low phase.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      shadow.check_result(out_data);
    end
  end

  function automatic op_item_t make_op(op_t op, logic signed [15:0] a,
                                       logic signed [15:0] b, logic [7:0] v);
    op_item_t it;
    it.op       = op;
    it.arg_a    = a;
    it.arg_b    = b;
    it.in_value = v;
    return it;
  endfunction

  // Most random items use small steps and offsets, so that the pointer stays
  // in one region of the tape and the same cells are read back and combined
  // over and over. The rest use the full 16-bit range of the step or offset.
  function automatic op_item_t random_op();
    op_item_t it;
    it.op       = op_t'($urandom_range(7));
    it.arg_a    = 16'($urandom);
    it.arg_b    = 16'($urandom);
    it.in_value = 8'($urandom);
    if ($urandom_range(99) < 75) begin
      it.arg_a = 16'($urandom_range(8)) - 16'd4;
    end
    return it;
  endfunction

  // Offers one item, possibly after some idle cycles, and waits for it to
  // be accepted. Valid stays high straight into the next item when no idle
  // cycle is drawn, so that back-to-back transfers are covered.
  task automatic send_op(input op_item_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (!in_ready);
    shadow.note_op(it);
  endtask

  // Stops offering items and waits until every expected result is back.
  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (shadow.pending_results.size() != 0) @(posedge clk);
  endtask

  // A counted-down loop as a compiled program would issue it: set a counter,
  // then repeat the body with a multiply-add into a neighbor until the
  // counter cell reads zero. The shadow tape decides when the loop exits.
  // The offset is never zero, so the multiply-add leaves the counter alone.
  task automatic run_count_loop(output int n_sent);
    logic signed [15:0] off;
    off = 16'($urandom_range(1, 3));
    if ($urandom_range(1) == 1) begin
      off = -off;
    end
    send_op(make_op(OP_CONST, 16'($urandom_range(1, 6)), 16'($urandom), 8'($urandom)));
    send_op(make_op(OP_LOOP, 16'($urandom), 16'($urandom), 8'($urandom)));
    n_sent = 2;
    do begin
      send_op(make_op(OP_MUL, off, 16'($urandom), 8'($urandom)));
      send_op(make_op(OP_ADD, -16'sd1, 16'($urandom), 8'($urandom)));
      send_op(make_op(OP_END_LOOP, 16'($urandom), 16'($urandom), 8'($urandom)));
      n_sent += 3;
    end while (shadow.cells[shadow.ptr] != 8'd0);
    send_op(make_op(OP_OUT, 16'($urandom), 16'($urandom), 8'($urandom)));
    n_sent++;
  endtask

  task automatic run_random(input int n_items);
    int sent;
    int n_loop;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(99) < 8) begin
        run_count_loop(n_loop);
        sent += n_loop;
      end else begin
        send_op(random_op());
        sent++;
      end
    end
  endtask

  initial begin
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_data       = '0;
    send_idle_pct = 0;
    shadow        = new;
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;

    // Directed part. The block is not ready until the clearing sweep ends,
    // so the first item simply waits for it.
    // Output of a freshly cleared cell, and a loop test on zero.
    send_op(make_op(OP_OUT,      16'sd0,      16'sd0,      8'h00));
    send_op(make_op(OP_LOOP,     16'sd0,      16'sd0,      8'hFF));
    // Steps at both extremes; only their low byte reaches the cell.
    send_op(make_op(OP_ADD,      16'sh7FFF,   16'sh7FFF,   8'hFF));
    send_op(make_op(OP_ADD,     -16'sh8000,  -16'sh8000,   8'h00));
    send_op(make_op(OP_OUT,      16'sd0,      16'sd0,      8'h55));
    send_op(make_op(OP_END_LOOP, 16'sd0,      16'sd0,      8'hAA));
    // Wide constant truncated to the cell width.
    send_op(make_op(OP_CONST,    16'sh1234,   16'sd0,      8'h00));
    // Multiply-add onto the current cell itself: cell times one plus factor.
    send_op(make_op(OP_MUL,      16'sd0,      16'sd3,      8'h00));
    // Negative offset that wraps to the last cell, with factor minus one.
    send_op(make_op(OP_MUL,     -16'sd1,     -16'sd1,      8'h00));
    send_op(make_op(OP_ADP,     -16'sd1,      16'sd0,      8'h00));
    send_op(make_op(OP_OUT,      16'sd0,      16'sd0,      8'h00));
    // Largest forward step, then the most negative one, which wraps to zero.
    send_op(make_op(OP_ADP,      16'sh7FFF,   16'sd0,      8'h00));
    send_op(make_op(OP_ADP,     -16'sh8000,   16'sd0,      8'h00));
    send_op(make_op(OP_IN,       16'sd0,      16'sd0,      8'hFF));
    send_op(make_op(OP_IN,       16'sd0,      16'sd0,      8'h00));
    send_op(make_op(OP_ADP,      16'sd2,      16'sd0,      8'h00));
    send_op(make_op(OP_CONST,   -16'sd1,      16'sd0,      8'h00));
    // Addition that wraps the cell back to zero.
    send_op(make_op(OP_ADD,      16'sd1,      16'sd0,      8'h00));
    send_op(make_op(OP_CONST,   -16'sh8000,   16'sd0,      8'h00));
    send_op(make_op(OP_CONST,    16'sh00C3,   16'sd0,      8'h00));
    // Wide factors, truncated: into the cell below by a wrapping offset, then into a cell further up the tape.
    send_op(make_op(OP_MUL,      16'sh7FFF,   16'sh7FFF,   8'h00));
    send_op(make_op(OP_MUL,      16'sd5,     -16'sh8000,   8'h00));
    send_op(make_op(OP_ADP,      16'sd5,      16'sd0,      8'h00));
    send_op(make_op(OP_OUT,      16'sd0,      16'sd0,      8'h00));
    send_op(make_op(OP_END_LOOP, 16'sd0,      16'sd0,      8'h00));
    drain();

    // Random part, one phase per idling pattern.
    send_idle_pct = 0;
    stall_pct     = 0;
    run_random(420);
    send_idle_pct = 64;
    stall_pct     = 0;
    run_random(420);
    send_idle_pct = 0;
    stall_pct     = 64;
    run_random(420);
    send_idle_pct = 16;
    stall_pct     = 16;
    run_random(420);
    drain();

    // Long output hold while items keep coming: the result register, the
    // execute stage and the reduction pipeline fill and in_ready must fall.
    // The drain afterwards is the sender's pause until all results are in.
    send_idle_pct = 0;
    stall_pct     = 0;
    hold_left     = 400;
    repeat (60) send_op(random_op());
    drain();

    // Let any stray result show up before the verdict.
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (shadow.mismatches == 0 && shadow.pending_results.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
hw/rtl/tme_pkg.sv
hw/rtl/tme_ram.sv
hw/rtl/tme_disp.sv
hw/rtl/tape_machine_op_executor.sv
bench/tape_machine_op_executor_tb.sv
